### rtl/core/bsrt_pkg.sv
// ============================================================================
// bsrt_pkg
// Shared types and constants for the block sequence reassembly tracker.
// ============================================================================
package bsrt_pkg;

   localparam int SEQ_SPACE = 128;                    // power of two
   localparam int TAG_BITS  = 32;
   localparam int IDX_W     = $clog2(SEQ_SPACE);
   localparam int CNT_W     = 8;                      // block_count port width
   localparam int RCV_W     = $clog2(SEQ_SPACE + 1);  // received count 0..SEQ_SPACE
   localparam int STAT_W    = 3;
   localparam int QDEPTH    = 2;
   localparam int QPTR_W    = $clog2(QDEPTH);
   localparam int QCNT_W    = $clog2(QDEPTH + 1);

   typedef enum logic [1:0] {
      OP_CREATE  = 2'd0,
      OP_INSERT  = 2'd1,
      OP_SEARCH  = 2'd2,
      OP_DESTROY = 2'd3
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK       = 3'd0,
      ST_DUP      = 3'd1,
      ST_TAG      = 3'd2,
      ST_RANGE    = 3'd3,
      ST_BUSY     = 3'd4,
      ST_BAD_CNT  = 3'd5,
      ST_NO_ENTRY = 3'd6,
      ST_ABSENT   = 3'd7
   } status_type;

   typedef enum logic {
      BK_FETCH = 1'b0,
      BK_EXEC  = 1'b1
   } back_state_type;

   // classified command, as queued between front and back
   typedef struct packed {
      op_type              op;
      logic [IDX_W-1:0]    entry;
      logic [IDX_W-1:0]    pos;
      logic [CNT_W-1:0]    cnt;
      logic                cnt_over;
      logic                cnt_zero;
      logic [TAG_BITS-1:0] tag;
   } cmd_type;

   // one table entry, stored as a single memory word
   typedef struct packed {
      logic [CNT_W-1:0]     block_count;
      logic [RCV_W-1:0]     received;
      logic [TAG_BITS-1:0]  tag;
      logic [SEQ_SPACE-1:0] slots;
   } entry_type;

endpackage

### rtl/core/bsrt_front.sv
// ============================================================================
// bsrt_front
// Accepts request transfers, reduces indexes and pre-checks the block count.
// ============================================================================
module bsrt_front
   import bsrt_pkg::*;
(
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [6:0]  req_start_index,
   input  logic [6:0]  req_block_index,
   input  logic [7:0]  req_block_count,
   input  logic [31:0] req_frame_tag,
   output logic        push_valid,
   input  logic        push_ready,
   output cmd_type     push_cmd
);

   logic [IDX_W-1:0] entry;
   logic [IDX_W-1:0] blk;

   assign req_ready  = push_ready;
   assign push_valid = req_valid;

   always_comb begin
      entry             = IDX_W'(req_start_index);
      blk               = IDX_W'(req_block_index);
      push_cmd.op       = op_type'(req_op);
      push_cmd.entry    = entry;
      push_cmd.pos      = blk - entry;   // wraps modulo the sequence space
      push_cmd.cnt      = CNT_W'(req_block_count);
      push_cmd.cnt_over = {1'b0, req_block_count} > (CNT_W + 1)'(SEQ_SPACE);
      push_cmd.cnt_zero = (req_block_count == '0);
      push_cmd.tag      = TAG_BITS'(req_frame_tag);
   end

endmodule

### rtl/core/bsrt_queue.sv
// ============================================================================
// bsrt_queue
// Short command queue decoupling the front from the table back end.
// ============================================================================
module bsrt_queue
   import bsrt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_cmd,
   output logic    pop_valid,
   input  logic    pop,
   output cmd_type pop_cmd
);

   cmd_type           slot_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign push_ready = (count_ff != QCNT_W'(QDEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### rtl/core/bsrt_back.sv
// ============================================================================
// bsrt_back
// Entry table: valid flops plus one memory word per entry, updated by a
// read-modify-write (fetch, then execute); drives the registered response.
// ============================================================================
module bsrt_back
   import bsrt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   output logic        cmd_pop,
   input  cmd_type     cmd_head,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [6:0]  rsp_slot_position,
   output logic        rsp_frame_complete,
   output logic [7:0]  rsp_received_total
);

   back_state_type       state_ff, state_in;
   cmd_type              cmd_ff;
   entry_type            mem [SEQ_SPACE];
   entry_type            rd_ff;
   logic [SEQ_SPACE-1:0] valid_ff, valid_in;

   logic                 out_free;
   logic                 commit;
   logic                 mem_wr;
   entry_type            mem_wdata;

   status_type           st;
   logic [IDX_W-1:0]     pos_o;
   logic                 done_o;
   logic [RCV_W-1:0]     total_o;

   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff;
   logic [IDX_W-1:0]     rsp_pos_ff;
   logic                 rsp_done_ff;
   logic [RCV_W-1:0]     rsp_total_ff;

   logic                 live;
   logic                 out_of_range;
   logic [RCV_W-1:0]     rcv_next;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_FETCH: if (cmd_valid) state_in = BK_EXEC;
         BK_EXEC:  if (out_free)  state_in = BK_FETCH;
         default:  state_in = BK_FETCH;
      endcase
   end

   // FSM outputs
   always_comb begin
      cmd_pop = 1'b0;
      commit  = 1'b0;
      case (state_ff)
         BK_FETCH: cmd_pop = cmd_valid;
         BK_EXEC:  commit  = out_free;
         default: begin
            cmd_pop = 1'b0;
            commit  = 1'b0;
         end
      endcase
   end

   // execute on the fetched entry
   always_comb begin
      live         = valid_ff[cmd_ff.entry];
      out_of_range = {1'b0, cmd_ff.pos} >= (IDX_W + 1)'(rd_ff.block_count);
      rcv_next     = rd_ff.received + 1'b1;
      st           = ST_OK;
      pos_o        = cmd_ff.pos;
      done_o       = 1'b0;
      total_o      = '0;
      mem_wr       = 1'b0;
      mem_wdata    = rd_ff;
      valid_in     = valid_ff;
      case (cmd_ff.op)
         OP_CREATE: begin
            pos_o = '0;
            if (cmd_ff.cnt_over)      st = ST_BAD_CNT;
            else if (live)            st = ST_BUSY;
            else if (cmd_ff.cnt_zero) st = ST_BAD_CNT;
            else begin
               mem_wr                = 1'b1;
               mem_wdata.block_count = cmd_ff.cnt;
               mem_wdata.received    = '0;
               mem_wdata.tag         = cmd_ff.tag;
               mem_wdata.slots       = '0;
               valid_in[cmd_ff.entry] = 1'b1;
            end
         end
         OP_DESTROY: begin
            pos_o = '0;
            if (!live) st = ST_NO_ENTRY;
            else       valid_in[cmd_ff.entry] = 1'b0;
         end
         OP_INSERT: begin
            if (!live) st = ST_NO_ENTRY;
            else begin
               total_o = rd_ff.received;
               done_o  = (rd_ff.received == RCV_W'(rd_ff.block_count));
               if (cmd_ff.tag != rd_ff.tag)     st = ST_TAG;
               else if (out_of_range)           st = ST_RANGE;
               else if (rd_ff.slots[cmd_ff.pos]) st = ST_DUP;
               else begin
                  mem_wr                      = 1'b1;
                  mem_wdata.slots[cmd_ff.pos] = 1'b1;
                  mem_wdata.received          = rcv_next;
                  total_o                     = rcv_next;
                  done_o = (rcv_next == RCV_W'(rd_ff.block_count));
               end
            end
         end
         OP_SEARCH: begin
            if (!live) st = ST_NO_ENTRY;
            else begin
               total_o = rd_ff.received;
               done_o  = (rd_ff.received == RCV_W'(rd_ff.block_count));
               if (out_of_range)                 st = ST_RANGE;
               else if (!rd_ff.slots[cmd_ff.pos]) st = ST_ABSENT;
            end
         end
         default: st = ST_OK;
      endcase
   end

   assign rsp_valid_in = commit ? 1'b1 : (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_FETCH;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (commit) begin
            valid_ff <= valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         cmd_ff <= cmd_head;
      end
      if (commit) begin
         rsp_status_ff <= st;
         rsp_pos_ff    <= pos_o;
         rsp_done_ff   <= done_o;
         rsp_total_ff  <= total_o;
      end
   end

   // entry memory: one read port, one write port, registered read data
   always_ff @(posedge clock) begin
      if (commit && mem_wr) begin
         mem[cmd_ff.entry] <= mem_wdata;
      end
      if (cmd_pop) begin
         rd_ff <= mem[cmd_head.entry];
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_slot_position  = 7'(rsp_pos_ff);
   assign rsp_frame_complete = rsp_done_ff;
   assign rsp_received_total = 8'(rsp_total_ff);

endmodule

### rtl/core/block_sequence_reassembly_tracker_core.sv
// Path: a request transfer goes through the command queue, an entry fetch
// and an execute step; rsp_valid is registered and rises when the response
// side is free. The back end takes a new request only after the previous
// one's read-modify-write of the entry memory is done.
// Reset: all entries invalid, queue empty, no response pending; table memory
// contents are not cleared and are rewritten on create.
// ============================================================================
// block_sequence_reassembly_tracker_core
// Frame reassembly tracker: front classifier, command queue, table back end.
// ============================================================================
module block_sequence_reassembly_tracker_core
   import bsrt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [6:0]  req_start_index,
   input  logic [6:0]  req_block_index,
   input  logic [7:0]  req_block_count,
   input  logic [31:0] req_frame_tag,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [6:0]  rsp_slot_position,
   output logic        rsp_frame_complete,
   output logic [7:0]  rsp_received_total
);

   logic    push_valid;
   logic    push_ready;
   cmd_type push_cmd;
   logic    pop_valid;
   logic    pop;
   cmd_type pop_cmd;

   bsrt_front u_front (
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_start_index (req_start_index),
      .req_block_index (req_block_index),
      .req_block_count (req_block_count),
      .req_frame_tag   (req_frame_tag),
      .push_valid      (push_valid),
      .push_ready      (push_ready),
      .push_cmd        (push_cmd)
   );

   bsrt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_cmd    (pop_cmd)
   );

   bsrt_back u_back (
      .clock              (clock),
      .reset              (reset),
      .cmd_valid          (pop_valid),
      .cmd_pop            (pop),
      .cmd_head           (pop_cmd),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_slot_position  (rsp_slot_position),
      .rsp_frame_complete (rsp_frame_complete),
      .rsp_received_total (rsp_received_total)
   );

endmodule

### rtl/core/bsrt_checker.sv
// ============================================================================
// bsrt_checker
// Port-level checks on the tracker's response channel.
// ============================================================================
module bsrt_checker
   import bsrt_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_status,
   input logic [6:0] rsp_slot_position,
   input logic       rsp_frame_complete,
   input logic [7:0] rsp_received_total
);

   // a stalled response transfer holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_slot_position) && $stable(rsp_frame_complete) &&
      $stable(rsp_received_total))
      else $error("response changed while stalled");

   // rejected creates carry no position or count
   a_create_reject: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_BUSY || rsp_status == ST_BAD_CNT) |->
      rsp_slot_position == '0 && !rsp_frame_complete && rsp_received_total == '0)
      else $error("create reject with nonzero fields");

   // missing entry reports no progress
   a_no_entry: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_NO_ENTRY |->
      !rsp_frame_complete && rsp_received_total == '0)
      else $error("no-entry response with progress");

   // count never exceeds the sequence space
   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> {1'b0, rsp_received_total} <= 9'(SEQ_SPACE))
      else $error("received total out of bound");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind block_sequence_reassembly_tracker_core bsrt_checker u_bsrt_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_status         (rsp_status),
   .rsp_slot_position  (rsp_slot_position),
   .rsp_frame_complete (rsp_frame_complete),
   .rsp_received_total (rsp_received_total)
);

### tb/reassembly_tracker_checker.sv
// ----------------------------------------------------------------------------
// reassembly_tracker_checker
// Watches both channels of the reassembly tracker, keeps its own copy of the
// frame table, predicts one response per request transfer and compares each
// response transfer with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module reassembly_tracker_checker
   import bsrt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [6:0]  req_start_index,
   input  logic [6:0]  req_block_index,
   input  logic [7:0]  req_block_count,
   input  logic [31:0] req_frame_tag,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [2:0]  rsp_status,
   input  logic [6:0]  rsp_slot_position,
   input  logic        rsp_frame_complete,
   input  logic [7:0]  rsp_received_total,
   output int          mismatch_count,
   output int          outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      status_type       status;
      logic [IDX_W-1:0] pos;
      logic             done;
      logic [7:0]       total;
   } outcome_type;

   bit                   live_entry   [SEQ_SPACE];
   logic [7:0]           frame_len    [SEQ_SPACE];
   logic [7:0]           blocks_in    [SEQ_SPACE];
   logic [TAG_BITS-1:0]  frame_tag_of [SEQ_SPACE];
   logic [SEQ_SPACE-1:0] filled       [SEQ_SPACE];
   outcome_type          expected_outcomes [$];

   initial begin
      mismatch_count = 0;
      outstanding    = 0;
   end

   task automatic report_mismatch(string what, int got_v, int exp_v);
      $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got_v, exp_v);
      mismatch_count++;
   endtask

   // applies one request to the table copy and returns the response it earns
   function automatic outcome_type track_request(op_type op, logic [6:0] first_seq,
                                                 logic [6:0] blk_seq, logic [7:0] cnt,
                                                 logic [31:0] tg);
      outcome_type r;
      logic [6:0]  pos;
      pos      = blk_seq - first_seq;   // 7-bit wrap is the modulo
      r.status = ST_OK;
      r.pos    = '0;
      r.done   = 1'b0;
      r.total  = '0;
      case (op)
         OP_CREATE: begin
            // an oversized count wins over a busy entry, a zero count does not
            if (cnt > SEQ_SPACE) r.status = ST_BAD_CNT;
            else if (live_entry[first_seq]) r.status = ST_BUSY;
            else if (cnt == 0) r.status = ST_BAD_CNT;
            else begin
               live_entry[first_seq]   = 1'b1;
               frame_len[first_seq]    = cnt;
               blocks_in[first_seq]    = '0;
               frame_tag_of[first_seq] = tg;
               filled[first_seq]       = '0;
            end
         end
         OP_DESTROY: begin
            if (!live_entry[first_seq]) r.status = ST_NO_ENTRY;
            else live_entry[first_seq] = 1'b0;
         end
         default: begin
            r.pos = pos;
            if (!live_entry[first_seq]) r.status = ST_NO_ENTRY;
            else begin
               r.total = blocks_in[first_seq];
               r.done  = (blocks_in[first_seq] == frame_len[first_seq]);
               if (op == OP_INSERT) begin
                  if (tg != frame_tag_of[first_seq]) r.status = ST_TAG;
                  else if (pos >= frame_len[first_seq]) r.status = ST_RANGE;
                  else if (filled[first_seq][pos]) r.status = ST_DUP;
                  else begin
                     filled[first_seq][pos] = 1'b1;
                     blocks_in[first_seq]   = blocks_in[first_seq] + 8'd1;
                     r.total = blocks_in[first_seq];
                     r.done  = (blocks_in[first_seq] == frame_len[first_seq]);
                  end
               end else begin
                  if (pos >= frame_len[first_seq]) r.status = ST_RANGE;
                  else r.status = filled[first_seq][pos] ? ST_OK : ST_ABSENT;
               end
            end
         end
      endcase
      return r;
   endfunction

   always @(posedge clock) begin : track
      outcome_type want;
      if (reset) begin
         expected_outcomes.delete();
         foreach (live_entry[i]) live_entry[i] = 1'b0;
      end else begin
         if (req_valid && req_ready)
            expected_outcomes.push_back(track_request(op_type'(req_op), req_start_index,
                                                      req_block_index, req_block_count,
                                                      req_frame_tag));
         if (rsp_valid && rsp_ready) begin
            if (expected_outcomes.size() == 0) begin
               report_mismatch("response transfer with none pending, status", rsp_status, -1);
            end else begin
               want = expected_outcomes.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", rsp_status, want.status);
               if (rsp_slot_position !== want.pos)
                  report_mismatch("slot_position", rsp_slot_position, want.pos);
               if (rsp_frame_complete !== want.done)
                  report_mismatch("frame_complete", rsp_frame_complete, want.done);
               if (rsp_received_total !== want.total)
                  report_mismatch("received_total", rsp_received_total, want.total);
            end
         end
      end
      outstanding = expected_outcomes.size();
   end

endmodule

### tb/block_sequence_reassembly_tracker_core_tb.sv
// ----------------------------------------------------------------------------
// block_sequence_reassembly_tracker_core_tb
// Drives frame create/insert/search/destroy traffic into the reassembly
// tracker: a directed pass over the corner cases, then random frame sessions
// mixed with noise, under three idling mixes and one long response stall.
// The checker beside the block does the prediction and comparison.
// ----------------------------------------------------------------------------
module block_sequence_reassembly_tracker_core_tb
   import bsrt_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEMS_PER_PHASE = 375;
   localparam int LONG_HOLD       = 400;
   localparam int CYCLE_LIMIT     = 200000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_op;
   logic [6:0]  req_start_index;
   logic [6:0]  req_block_index;
   logic [7:0]  req_block_count;
   logic [31:0] req_frame_tag;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [2:0]  rsp_status;
   logic [6:0]  rsp_slot_position;
   logic        rsp_frame_complete;
   logic [7:0]  rsp_received_total;

   int mismatch_count;
   int outstanding;
   int items_sent     = 0;
   int cycle_count    = 0;
   int send_idle_pct  = 34;
   int recv_idle_pct  = 77;
   bit long_hold_req  = 1'b0;

   block_sequence_reassembly_tracker_core i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_op             (req_op),
      .req_start_index    (req_start_index),
      .req_block_index    (req_block_index),
      .req_block_count    (req_block_count),
      .req_frame_tag      (req_frame_tag),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_slot_position  (rsp_slot_position),
      .rsp_frame_complete (rsp_frame_complete),
      .rsp_received_total (rsp_received_total)
   );

   reassembly_tracker_checker i_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_op             (req_op),
      .req_start_index    (req_start_index),
      .req_block_index    (req_block_index),
      .req_block_count    (req_block_count),
      .req_frame_tag      (req_frame_tag),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_slot_position  (rsp_slot_position),
      .rsp_frame_complete (rsp_frame_complete),
      .rsp_received_total (rsp_received_total),
      .mismatch_count     (mismatch_count),
      .outstanding        (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAILURE");
      $finish;
   end

   // response side: random back-pressure plus one long hold-off on request
   initial begin : receiver
      int  hold_left;
      bit  hold_taken;
      hold_left  = 0;
      hold_taken = 1'b0;
      rsp_ready  = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (long_hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = LONG_HOLD - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // called at a rising edge; returns at the edge where the transfer happens
   task automatic send_item(op_type op, logic [6:0] first_seq, logic [6:0] blk_seq,
                            logic [7:0] cnt, logic [31:0] tg);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_op          <= op;
      req_start_index <= first_seq;
      req_block_index <= blk_seq;
      req_block_count <= cnt;
      req_frame_tag   <= tg;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic send_noise();
      send_item(op_type'($urandom_range(3)), 7'($urandom_range(127)),
                7'($urandom_range(127)), 8'($urandom_range(255)), $urandom);
   endtask

   // one frame's life: create, blocks in random order with the odd detour,
   // a final search and usually a destroy
   task automatic run_frame_session();
      int          first_seq;
      int          n;
      int          pick;
      int          j;
      int          tmp;
      int          off;
      bit          abandon;
      logic [31:0] tg;
      int          order [128];
      first_seq = $urandom_range(127);
      pick      = $urandom_range(99);
      if (pick < 80) n = $urandom_range(1, 10);
      else if (pick < 95) n = $urandom_range(11, 40);
      else n = $urandom_range(120, 128);
      tg = $urandom;
      send_item(OP_CREATE, 7'(first_seq), 7'($urandom_range(127)), 8'(n), tg);
      for (int k = 0; k < n; k++) order[k] = k;
      for (int k = n - 1; k > 0; k--) begin
         j        = $urandom_range(k);
         tmp      = order[k];
         order[k] = order[j];
         order[j] = tmp;
      end
      abandon = 1'b0;
      for (int k = 0; k < n && !abandon; k++) begin
         send_item(OP_INSERT, 7'(first_seq), 7'(first_seq + order[k]),
                   8'($urandom_range(255)), tg);
         if ($urandom_range(99) < 12) begin
            case ($urandom_range(3))
               0: off = order[$urandom_range(k)];                 // duplicate
               1: off = $urandom_range(n - 1);
               2: off = (n < 128) ? $urandom_range(n, 127) : 0;   // past the frame
               default: off = $urandom_range(127);
            endcase
            if ($urandom_range(3) == 1)
               send_item(OP_INSERT, 7'(first_seq), 7'(first_seq + off),
                         8'($urandom_range(255)), tg ^ (32'd1 << $urandom_range(31)));
            else if ($urandom_range(1) == 0)
               send_item(OP_INSERT, 7'(first_seq), 7'(first_seq + off),
                         8'($urandom_range(255)), tg);
            else
               send_item(OP_SEARCH, 7'(first_seq), 7'(first_seq + off),
                         8'($urandom_range(255)), $urandom);
         end
         if ($urandom_range(99) < 2) abandon = 1'b1;
      end
      send_item(OP_SEARCH, 7'(first_seq), 7'(first_seq + $urandom_range(n - 1)),
                8'($urandom_range(255)), $urandom);
      if ($urandom_range(99) < 90)
         send_item(OP_DESTROY, 7'(first_seq), 7'($urandom_range(127)),
                   8'($urandom_range(255)), $urandom);
   endtask

   initial begin : stimulus
      int target;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_op          = OP_CREATE;
      req_start_index = '0;
      req_block_index = '0;
      req_block_count = '0;
      req_frame_tag   = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // corner cases on an empty table, count limits and error precedence
      send_item(OP_DESTROY, 7'd5,   7'd0,   8'd0,   32'h0);
      send_item(OP_INSERT,  7'd5,   7'd7,   8'd0,   32'h0);
      send_item(OP_SEARCH,  7'd5,   7'd4,   8'd0,   32'h0);
      send_item(OP_CREATE,  7'd0,   7'd0,   8'd0,   32'h0);
      send_item(OP_CREATE,  7'd0,   7'd0,   8'd255, 32'h0);
      send_item(OP_CREATE,  7'd0,   7'd0,   8'd129, 32'h0);
      send_item(OP_CREATE,  7'd127, 7'd127, 8'd128, 32'hFFFF_FFFF);
      send_item(OP_CREATE,  7'd127, 7'd0,   8'd200, 32'h0);
      send_item(OP_CREATE,  7'd127, 7'd0,   8'd0,   32'h0);
      send_item(OP_CREATE,  7'd127, 7'd0,   8'd5,   32'h0);
      send_item(OP_INSERT,  7'd127, 7'd127, 8'd0,   32'h0);
      send_item(OP_INSERT,  7'd127, 7'd127, 8'd0,   32'hFFFF_FFFF);
      send_item(OP_INSERT,  7'd127, 7'd0,   8'd255, 32'hFFFF_FFFF);  // wraps to slot 1
      send_item(OP_INSERT,  7'd127, 7'd0,   8'd0,   32'hFFFF_FFFF);
      send_item(OP_SEARCH,  7'd127, 7'd1,   8'd0,   32'h0);
      send_item(OP_SEARCH,  7'd127, 7'd0,   8'd0,   32'h0);
      send_item(OP_DESTROY, 7'd127, 7'd0,   8'd0,   32'h0);
      send_item(OP_CREATE,  7'd64,  7'd0,   8'd2,   32'h0);
      send_item(OP_INSERT,  7'd64,  7'd63,  8'd0,   32'h0);
      send_item(OP_SEARCH,  7'd64,  7'd66,  8'd0,   32'h0);
      send_item(OP_INSERT,  7'd64,  7'd64,  8'd0,   32'h0);
      send_item(OP_INSERT,  7'd64,  7'd65,  8'd0,   32'h0);
      send_item(OP_SEARCH,  7'd64,  7'd65,  8'd0,   32'h0);
      send_item(OP_INSERT,  7'd64,  7'd65,  8'd0,   32'h0);
      send_item(OP_DESTROY, 7'd64,  7'd127, 8'd255, 32'h0);

      for (int ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin send_idle_pct <= 34; recv_idle_pct <= 77; end
            1: begin send_idle_pct <= 77; recv_idle_pct <= 34; end
            default: begin
               send_idle_pct <= 0;
               recv_idle_pct <= 0;
               long_hold_req <= 1'b1;   // block fills and stalls its input
            end
         endcase
         target = items_sent + ITEMS_PER_PHASE;
         while (items_sent < target) begin
            if ($urandom_range(99) < 15) send_noise();
            else run_frame_session();
         end
      end
      req_valid <= 1'b0;

      // one edge first so the last transfer is already counted as pending
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule
